@@ rtl/rtcab_pkg.sv @@
// rtcab_pkg: shared types and constants of the rtc alarm register block
// item structs, register offsets and the nanosecond scale factor
// no dependencies
`timescale 1ns / 1ps

package rtcab_pkg;

    localparam int unsigned SEC_W  = 34;
    localparam int unsigned NS_W   = 64;
    localparam int unsigned DATA_W = 32;
    localparam int unsigned OFF_W  = 12;
    localparam int unsigned SCALE_W = 30;

    // nanoseconds per second, fits in 30 bits
    localparam logic [SCALE_W-1:0] NS_PER_SECOND = 30'd1000000000;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    localparam logic [OFF_W-1:0] OFF_TIME_LOW     = 12'h000;
    localparam logic [OFF_W-1:0] OFF_TIME_HIGH    = 12'h004;
    localparam logic [OFF_W-1:0] OFF_ALARM_LOW    = 12'h008;
    localparam logic [OFF_W-1:0] OFF_ALARM_HIGH   = 12'h00C;
    localparam logic [OFF_W-1:0] OFF_IRQ_ENABLED  = 12'h010;
    localparam logic [OFF_W-1:0] OFF_ALARM_CLEAR  = 12'h014;
    localparam logic [OFF_W-1:0] OFF_ALARM_STATUS = 12'h018;
    localparam logic [OFF_W-1:0] OFF_IRQ_CLEAR    = 12'h01C;

    typedef struct packed {
        logic              opcode;
        logic [OFF_W-1:0]  register_offset;
        logic [DATA_W-1:0] write_data;
        logic [SEC_W-1:0]  now_seconds;
    } t_in_item;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              irq_level;
    } t_out_item;

    // access with the time already scaled to nanoseconds
    typedef struct packed {
        logic              opcode;
        logic [OFF_W-1:0]  register_offset;
        logic [DATA_W-1:0] write_data;
        logic [NS_W-1:0]   now_ns;
    } t_ns_item;

endpackage

@@ rtl/rtcab_ns_conv.sv @@
// rtcab_ns_conv: input register and seconds-to-nanoseconds stage
// two registered stages with chained flow control; uses rtcab_pkg
`timescale 1ns / 1ps

module rtcab_ns_conv (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  rtcab_pkg::t_in_item i_item,
    output logic                o_valid,
    input  logic                i_drain_ready,
    output rtcab_pkg::t_ns_item o_item
);
    import rtcab_pkg::*;

    logic     r_s1_valid;
    t_in_item r_s1_item;
    logic     r_s2_valid;
    t_ns_item r_s2_item;
    t_ns_item n_s2_item;

    logic                      s1_ready;
    logic                      s2_ready;
    logic [DATA_W+SCALE_W-1:0] prod_lo;
    logic [DATA_W-1:0]         prod_hi;

    assign s2_ready = !r_s2_valid || i_drain_ready;
    assign s1_ready = !r_s1_valid || s2_ready;
    assign o_stall  = !s1_ready;

    // split 34-bit seconds: low 32 bits times scale, top 2 bits times scale
    always_comb begin
        prod_lo = (DATA_W+SCALE_W)'(r_s1_item.now_seconds[DATA_W-1:0])
                  * (DATA_W+SCALE_W)'(NS_PER_SECOND);
        prod_hi = DATA_W'(r_s1_item.now_seconds[SEC_W-1:DATA_W])
                  * DATA_W'(NS_PER_SECOND);
        n_s2_item.opcode          = r_s1_item.opcode;
        n_s2_item.register_offset = r_s1_item.register_offset;
        n_s2_item.write_data      = r_s1_item.write_data;
        n_s2_item.now_ns          = NS_W'(prod_lo) + {prod_hi, {DATA_W{1'b0}}};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (s1_ready) begin
                r_s1_valid <= i_valid;
            end
            if (s2_ready) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready && i_valid) begin
            r_s1_item <= i_item;
        end
        if (s2_ready && r_s1_valid) begin
            r_s2_item <= n_s2_item;
        end
    end

    assign o_valid = r_s2_valid;
    assign o_item  = r_s2_item;

endmodule

@@ rtl/rtcab_regfile.sv @@
// rtcab_regfile: register decode, alarm state and alarm check
// updates state when an item leaves the nanosecond stage; uses rtcab_pkg
`timescale 1ns / 1ps

module rtcab_regfile (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_fire,
    input  rtcab_pkg::t_ns_item  i_item,
    output rtcab_pkg::t_out_item o_result
);
    import rtcab_pkg::*;

    // low latched half is only ever read right after it is taken, so only
    // the high half needs storage
    logic [DATA_W-1:0] r_latched_high;
    logic [DATA_W-1:0] r_alarm_low;
    logic [DATA_W-1:0] r_alarm_high;
    logic              r_armed;
    logic              r_enable;
    logic              r_line;

    logic [DATA_W-1:0] n_latched_high;
    logic [DATA_W-1:0] n_alarm_low;
    logic [DATA_W-1:0] n_alarm_high;
    logic              n_armed;
    logic              n_enable;
    logic              n_line;

    logic              is_wr;
    logic              run_check;
    logic              due;
    logic [DATA_W-1:0] rdata;

    assign is_wr = (i_item.opcode == OP_WRITE);

    always_comb begin
        n_alarm_low  = r_alarm_low;
        n_alarm_high = r_alarm_high;
        n_armed      = r_armed;
        n_enable     = r_enable;
        run_check    = 1'b0;
        rdata        = '0;
        if (is_wr) begin
            unique case (i_item.register_offset)
                OFF_ALARM_LOW: begin
                    n_alarm_low = i_item.write_data;
                    n_armed     = 1'b1;
                    run_check   = 1'b1;
                end
                OFF_ALARM_HIGH: begin
                    n_alarm_high = i_item.write_data;
                end
                OFF_IRQ_ENABLED: begin
                    n_enable  = i_item.write_data[0];
                    run_check = 1'b1;
                end
                OFF_ALARM_CLEAR: begin
                    n_armed   = 1'b0;
                    run_check = 1'b1;
                end
                OFF_IRQ_CLEAR: begin
                    run_check = 1'b1;
                end
                default: begin
                end
            endcase
        end else begin
            unique case (i_item.register_offset)
                OFF_TIME_LOW: begin
                    run_check = 1'b1;
                    rdata     = i_item.now_ns[DATA_W-1:0];
                end
                OFF_TIME_HIGH:    rdata = r_latched_high;
                OFF_ALARM_LOW:    rdata = r_alarm_low;
                OFF_ALARM_HIGH:   rdata = r_alarm_high;
                OFF_IRQ_ENABLED:  rdata = DATA_W'(r_enable);
                OFF_ALARM_STATUS: rdata = DATA_W'(r_armed);
                default: begin
                end
            endcase
        end

        // alarm check against the updated alarm and control bits
        due            = (i_item.now_ns >= {n_alarm_high, n_alarm_low});
        n_latched_high = r_latched_high;
        n_line         = r_line;
        if (run_check) begin
            n_latched_high = i_item.now_ns[NS_W-1:DATA_W];
            if (n_armed && n_enable) begin
                n_line = r_line || due;
            end else begin
                n_line = 1'b0;
            end
        end

        o_result.read_data = rdata;
        o_result.irq_level = n_line;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_latched_high <= '0;
            r_alarm_low    <= '0;
            r_alarm_high   <= '0;
            r_armed        <= 1'b0;
            r_enable       <= 1'b0;
            r_line         <= 1'b0;
        end else if (i_fire) begin
            r_latched_high <= n_latched_high;
            r_alarm_low    <= n_alarm_low;
            r_alarm_high   <= n_alarm_high;
            r_armed        <= n_armed;
            r_enable       <= n_enable;
            r_line         <= n_line;
        end
    end

`ifndef SYNTHESIS
    // the line can only be up while the alarm is armed and enabled
    a_line_needs_arm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line |-> (r_armed && r_enable))
        else $error("irq line raised while disarmed or disabled");

    // an alarm clear leaves the alarm disarmed and the line low
    a_clear_lowers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && is_wr && (i_item.register_offset == OFF_ALARM_CLEAR))
        |=> (!r_armed && !r_line))
        else $error("alarm clear did not disarm and lower the line");
`endif

endmodule

@@ rtl/rtc_alarm_register_block.sv @@
// rtc_alarm_register_block: top level of the rtc alarm register block
// one item per cycle sustained while the consumer does not stall
// the seconds-to-nanoseconds multiply has its own stage; all state updates
// happen in the single check stage, so back-to-back items see each other
// reset (synchronous, active low) empties the pipeline and clears all state
`timescale 1ns / 1ps

module rtc_alarm_register_block (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // access channel
    input  logic                 i_valid,
    output logic                 o_stall,
    input  rtcab_pkg::t_in_item  i_item,
    // result channel
    output logic                 o_valid,
    input  logic                 i_stall,
    output rtcab_pkg::t_out_item o_item
);
    import rtcab_pkg::*;

    // pipeline: input register -> product register -> check + result register
    logic      s2_valid;
    t_ns_item  s2_item;
    logic      out_ready;
    logic      fire;
    t_out_item result;

    logic      r_out_valid;
    t_out_item r_out_item;

    // the result register takes a new item when empty or being drained
    assign out_ready = !r_out_valid || !i_stall;
    // an item leaves the product stage and commits its state changes
    assign fire      = s2_valid && out_ready;

    rtcab_ns_conv u_ns_conv (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_item        (i_item),
        .o_valid       (s2_valid),
        .i_drain_ready (out_ready),
        .o_item        (s2_item)
    );

    rtcab_regfile u_regfile (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (s2_item),
        .o_result (result)
    );

    // result register, holds while the consumer stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_item <= result;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out_item;

`ifndef SYNTHESIS
    // a result only appears after an item sat in the product stage
    a_out_from_s2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(s2_valid))
        else $error("result valid without an item in the product stage");
`endif

endmodule

@@ verif/rtc_alarm_register_block_test.sv @@
// rtc_alarm_register_block_test: self-checking bench for the rtc alarm register block
// directed table then alarm sequences and noise, checked against typed expectations or an in-bench predictor
// depends on rtcab_pkg and rtc_alarm_register_block
`timescale 1ns / 1ps

module rtc_alarm_register_block_test;

    import rtcab_pkg::*;

    localparam int  N_RANDOM    = 600;
    localparam int  LONG_HOLD   = 250;      // receiver hold-off used to back up the pipeline
    localparam int  DRAIN_WAIT  = 10;       // extra wait after the drain to catch stray results
    localparam int  CYCLE_LIMIT = 300000;
    localparam bit  TYPED       = 1'b1;     // row carries its own expected result
    localparam bit  PREDICTED   = 1'b0;     // row is checked against the predictor

    localparam logic [SEC_W-1:0] SEC_MAX = 34'h3_FFFF_FFFF;
    localparam logic [NS_W-1:0]  NS_SCALE = 64'd1_000_000_000;

    typedef struct packed {
        logic      typed;
        t_in_item  acc;
        t_out_item res;
    } t_dir_row;

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    always #1 clk = ~clk;

    // access channel
    logic      in_valid = 1'b0;
    logic      in_stall;
    t_in_item  in_item  = '0;
    // result channel
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_item;

    rtc_alarm_register_block uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_valid (in_valid),
        .o_stall (in_stall),
        .i_item  (in_item),
        .o_valid (out_valid),
        .i_stall (out_stall),
        .o_item  (out_item)
    );

    // predictor state, mirrors the block's registers from reset
    logic [31:0] time_snap_lo = '0;
    logic [31:0] time_snap_hi = '0;
    logic [31:0] alarm_lo     = '0;
    logic [31:0] alarm_hi     = '0;
    logic        alarm_armed  = 1'b0;
    logic        irq_enable   = 1'b0;
    logic        irq_line     = 1'b0;

    t_out_item   pending_results [$];   // expected results, oldest first
    int          err_count   = 0;
    int          n_sent      = 0;
    int          n_checked   = 0;
    int          n_in_held   = 0;       // cycles the block held off an offered item
    int          cycle_count = 0;
    bit          no_gaps     = 1'b0;    // sender runs back to back while set
    bit          long_hold_req = 1'b0;  // sender asks the receiver for one long hold-off
    logic [SEC_W-1:0] now_sec = '0;     // bench wall clock, mostly creeping forward

    // seconds to nanoseconds, latch the snapshot, then update the interrupt line
    task automatic alarm_check(input logic [SEC_W-1:0] secs);
        logic [NS_W-1:0] now_ns;
        now_ns = {30'd0, secs} * NS_SCALE;
        time_snap_lo = now_ns[31:0];
        time_snap_hi = now_ns[63:32];
        if (alarm_armed && irq_enable) begin
            // a due alarm raises the line; not yet due leaves it as it is
            if (now_ns >= {alarm_hi, alarm_lo})
                irq_line = 1'b1;
        end else begin
            irq_line = 1'b0;
        end
    endtask

    task automatic predict_access(input t_in_item a, output t_out_item r);
        logic [31:0] rd;
        rd = '0;
        if (a.opcode == OP_READ) begin
            case (a.register_offset)
                OFF_TIME_LOW: begin
                    alarm_check(a.now_seconds);
                    rd = time_snap_lo;
                end
                OFF_TIME_HIGH:    rd = time_snap_hi;
                OFF_ALARM_LOW:    rd = alarm_lo;
                OFF_ALARM_HIGH:   rd = alarm_hi;
                OFF_IRQ_ENABLED:  rd = {31'd0, irq_enable};
                OFF_ALARM_STATUS: rd = {31'd0, alarm_armed};
                default:          rd = '0;     // write-only, unaligned or unmapped
            endcase
        end else begin
            case (a.register_offset)
                OFF_ALARM_LOW: begin
                    alarm_armed = 1'b1;
                    alarm_lo    = a.write_data;
                    alarm_check(a.now_seconds);
                end
                OFF_ALARM_HIGH:  alarm_hi = a.write_data;
                OFF_IRQ_ENABLED: begin
                    irq_enable = a.write_data[0];
                    alarm_check(a.now_seconds);
                end
                OFF_ALARM_CLEAR: begin
                    alarm_armed = 1'b0;
                    alarm_check(a.now_seconds);
                end
                OFF_IRQ_CLEAR:   alarm_check(a.now_seconds);
                default: ;                     // read-only or unmapped, ignored
            endcase
        end
        r.read_data = rd;
        r.irq_level = irq_line;
    endtask

    function automatic t_in_item make_access(logic op, logic [OFF_W-1:0] off,
                                             logic [31:0] wd, logic [SEC_W-1:0] secs);
        t_in_item a;
        a.opcode          = op;
        a.register_offset = off;
        a.write_data      = wd;
        a.now_seconds     = secs;
        return a;
    endfunction

    function automatic t_dir_row row(logic typed, logic op, logic [OFF_W-1:0] off,
                                     logic [31:0] wd, logic [SEC_W-1:0] secs,
                                     logic [31:0] rd, logic irq);
        t_dir_row d;
        d.typed         = typed;
        d.acc           = make_access(op, off, wd, secs);
        d.res.read_data = rd;
        d.res.irq_level = irq;
        return d;
    endfunction

    // offer one item, hold it until accepted, then record what must come back
    task automatic drive_access(input t_in_item a, input logic typed, input t_out_item typed_res);
        t_out_item r;
        in_item  <= a;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        predict_access(a, r);
        pending_results.push_back(typed ? typed_res : r);
        n_sent++;
    endtask

    task automatic send(input t_in_item a);
        drive_access(a, PREDICTED, '0);
        sender_gap();
    endtask

    // mostly back to back, sometimes a short gap, now and then a long one
    task automatic sender_gap();
        int pick;
        int n;
        if (no_gaps)
            return;
        pick = $urandom_range(0, 9);
        if (pick < 6)
            n = 0;
        else if (pick < 9)
            n = $urandom_range(1, 3);
        else
            n = $urandom_range(8, 30);
        if (n > 0) begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // set the alarm near the bench clock, sometimes write the enable, arm it, then poll the time as it creeps up
    task automatic alarm_sequence();
        logic [NS_W-1:0] now_ns;
        logic [NS_W-1:0] alarm_ns;
        logic [31:0]     en_data;
        int              polls;
        now_ns = {30'd0, now_sec} * NS_SCALE;
        if ($urandom_range(0, 3) == 0)
            alarm_ns = now_ns - 64'($urandom_range(0, 999_999_999));   // already due
        else
            alarm_ns = now_ns + 64'($urandom_range(0, 6)) * NS_SCALE
                       + 64'($urandom_range(0, 999_999_999));
        send(make_access(OP_WRITE, OFF_ALARM_HIGH, alarm_ns[63:32], SEC_W'($urandom())));
        if ($urandom_range(0, 2) != 0) begin
            en_data = $urandom();
            en_data[0] = ($urandom_range(0, 4) != 0);
            send(make_access(OP_WRITE, OFF_IRQ_ENABLED, en_data, now_sec));
        end
        send(make_access(OP_WRITE, OFF_ALARM_LOW, alarm_ns[31:0], now_sec));
        polls = $urandom_range(2, 8);
        repeat (polls) begin
            now_sec = now_sec + SEC_W'($urandom_range(0, 2));
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: send(make_access(OP_READ, OFF_TIME_LOW, $urandom(), now_sec));
                5: send(make_access(OP_READ, OFF_TIME_HIGH, $urandom(), now_sec));
                6: send(make_access(OP_WRITE, OFF_IRQ_CLEAR, $urandom(), now_sec));
                7: send(make_access(OP_READ, $urandom_range(0, 1) ? OFF_ALARM_STATUS
                                                               : OFF_IRQ_ENABLED,
                                    $urandom(), now_sec));
                8: send(make_access(OP_READ, $urandom_range(0, 1) ? OFF_ALARM_LOW
                                                               : OFF_ALARM_HIGH,
                                    $urandom(), now_sec));
                default: send(make_access(OP_WRITE, OFF_IRQ_ENABLED, $urandom(), now_sec));
            endcase
        end
        case ($urandom_range(0, 3))
            0: send(make_access(OP_WRITE, OFF_ALARM_CLEAR, $urandom(), now_sec));
            1: send(make_access(OP_WRITE, OFF_IRQ_ENABLED, 32'd0, now_sec));
            default: ;
        endcase
    endtask

    // random kind, offset anywhere in the window or among the first few words
    task automatic noise_access();
        logic [OFF_W-1:0] off;
        logic [SEC_W-1:0] secs;
        off  = $urandom_range(0, 1) ? OFF_W'($urandom_range(0, 4095))
                                    : OFF_W'($urandom_range(0, 31));
        secs = $urandom_range(0, 1) ? now_sec
                                    : {2'($urandom_range(0, 3)), 32'($urandom())};
        send(make_access(1'($urandom_range(0, 1)), off, $urandom(), secs));
    endtask

    // compare each accepted result with the oldest expectation
    always @(posedge clk) begin
        t_out_item exp_res;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: read_data %h irq_level %b",
                       out_item.read_data, out_item.irq_level);
                err_count++;
            end else begin
                exp_res = pending_results.pop_front();
                n_checked++;
                if (out_item.read_data !== exp_res.read_data) begin
                    $error("read_data expected %h actual %h",
                           exp_res.read_data, out_item.read_data);
                    err_count++;
                end
                if (out_item.irq_level !== exp_res.irq_level) begin
                    $error("irq_level expected %b actual %b",
                           exp_res.irq_level, out_item.irq_level);
                    err_count++;
                end
            end
        end
        if (rst_n && in_valid && in_stall)
            n_in_held++;
    end

    // watchdog
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("rtc_alarm_register_block verification failed");
            $finish;
        end
    end

    // receiver: free-running stretches, short and long stalls, one long hold on request
    initial begin : rx_stall_gen
        int pick;
        int n;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (long_hold_req) begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                long_hold_req = 1'b0;
            end else begin
                pick = $urandom_range(0, 9);
                if (pick < 5) begin
                    out_stall <= 1'b0;
                    n = $urandom_range(1, 20);
                end else if (pick < 9) begin
                    out_stall <= 1'b1;
                    n = $urandom_range(1, 3);
                end else begin
                    out_stall <= 1'b1;
                    n = $urandom_range(15, 50);
                end
                repeat (n) @(posedge clk);
            end
        end
    end

    // sender: reset, directed table, random part with pressure phases, drain, verdict
    initial begin : tx_main
        t_dir_row dir_rows [$];
        int       n_directed;
        bit       hold_done;
        bit       drain_done;

        // directed table: reset values, extremes, ignored accesses and irq clear behavior
        dir_rows = '{
            // reset state
            row(TYPED, OP_READ,  OFF_TIME_HIGH,     32'hFFFF_FFFF, '0,      32'd0, 1'b0),
            row(TYPED, OP_READ,  OFF_ALARM_STATUS,  32'd0,         '0,      32'd0, 1'b0),
            row(TYPED, OP_READ,  OFF_TIME_LOW,      32'd0,         '0,      32'd0, 1'b0),
            // largest time, no wrap in the nanosecond scale
            row(PREDICTED, OP_READ, OFF_TIME_LOW,   32'd0,         SEC_MAX, 32'd0, 1'b0),
            row(PREDICTED, OP_READ, OFF_TIME_HIGH,  32'd0,         SEC_MAX, 32'd0, 1'b0),
            // enable keeps only bit 0
            row(TYPED, OP_WRITE, OFF_ALARM_HIGH,    32'd0,         '0,      32'd0, 1'b0),
            row(TYPED, OP_WRITE, OFF_IRQ_ENABLED,   32'hFFFF_FFFE, '0,      32'd0, 1'b0),
            row(TYPED, OP_READ,  OFF_IRQ_ENABLED,   32'd0,         '0,      32'd0, 1'b0),
            row(TYPED, OP_WRITE, OFF_IRQ_ENABLED,   32'd1,         '0,      32'd0, 1'b0),
            // arm with alarm not yet due: line stays low
            row(TYPED, OP_WRITE, OFF_ALARM_LOW,     32'hFFFF_FFFF, '0,      32'd0, 1'b0),
            row(TYPED, OP_READ,  OFF_ALARM_STATUS,  32'd0,         '0,      32'd1, 1'b0),
            row(TYPED, OP_READ,  OFF_ALARM_LOW,     32'd0,         '0,
                32'hFFFF_FFFF, 1'b0),
            // time passes the alarm: line rises
            row(PREDICTED, OP_READ, OFF_TIME_LOW,   32'd0,         34'd5,   32'd0, 1'b0),
            // irq clear only re-evaluates, a raised line stays up
            row(TYPED, OP_WRITE, OFF_IRQ_CLEAR,     32'hFFFF_FFFF, '0,      32'd0, 1'b1),
            // reads of write-only registers
            row(TYPED, OP_READ,  OFF_ALARM_CLEAR,   32'd0,         '0,      32'd0, 1'b1),
            row(TYPED, OP_READ,  OFF_IRQ_CLEAR,     32'd0,         '0,      32'd0, 1'b1),
            // writes to read-only registers: no check, snapshot untouched
            row(TYPED, OP_WRITE, OFF_TIME_LOW,      32'hA5A5_A5A5, SEC_MAX, 32'd0, 1'b1),
            row(TYPED, OP_READ,  OFF_TIME_HIGH,     32'd0,         SEC_MAX, 32'd0, 1'b1),
            row(TYPED, OP_WRITE, OFF_ALARM_STATUS,  32'hFFFF_FFFF, SEC_MAX, 32'd0, 1'b1),
            row(TYPED, OP_WRITE, OFF_TIME_HIGH,     32'hFFFF_FFFF, SEC_MAX, 32'd0, 1'b1),
            // unaligned and unmapped
            row(TYPED, OP_READ,  12'h009,           32'hFFFF_FFFF, SEC_MAX, 32'd0, 1'b1),
            row(TYPED, OP_WRITE, 12'hFFF,           32'hFFFF_FFFF, SEC_MAX, 32'd0, 1'b1),
            // disarm lowers the line
            row(TYPED, OP_WRITE, OFF_ALARM_CLEAR,   32'd0,         SEC_MAX, 32'd0, 1'b0),
            // largest alarm never becomes due
            row(TYPED, OP_WRITE, OFF_ALARM_HIGH,    32'hFFFF_FFFF, SEC_MAX, 32'd0, 1'b0),
            row(TYPED, OP_WRITE, OFF_ALARM_LOW,     32'hFFFF_FFFF, SEC_MAX, 32'd0, 1'b0),
            // disable lowers the line
            row(TYPED, OP_WRITE, OFF_IRQ_ENABLED,   32'd0,         SEC_MAX, 32'd0, 1'b0)
        };

        // hold reset, then release it at a rising edge
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i]) begin
            drive_access(dir_rows[i].acc, dir_rows[i].typed, dir_rows[i].res);
            sender_gap();
        end
        n_directed = n_sent;

        // random part: mostly armed alarm sequences, the rest noise
        hold_done  = 1'b0;
        drain_done = 1'b0;
        while (n_sent < n_directed + N_RANDOM) begin
            // pressure: receiver holds off while items keep coming back to back
            if (!hold_done && n_sent >= n_directed + 200) begin
                hold_done     = 1'b1;
                long_hold_req = 1'b1;
                no_gaps       = 1'b1;
                repeat (40) noise_access();
                no_gaps       = 1'b0;
            end
            // sender goes quiet until everything outstanding has come back
            if (!drain_done && n_sent >= n_directed + 400) begin
                drain_done = 1'b1;
                in_valid <= 1'b0;
                while (pending_results.size() != 0) @(posedge clk);
            end
            // occasionally jump the clock anywhere in the 34-bit range
            if ($urandom_range(0, 9) == 0)
                now_sec = {2'($urandom_range(0, 3)), 32'($urandom())};
            no_gaps = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) < 7)
                alarm_sequence();
            else
                repeat ($urandom_range(1, 6)) noise_access();
            no_gaps = 1'b0;
        end
        in_valid <= 1'b0;

        // drain, then wait out DRAIN_WAIT to catch stray results
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("run covered %0d accesses (%0d directed), %0d results checked",
                 n_sent, n_directed, n_checked);
        $display("input held off for %0d cycles, %0d mismatches", n_in_held, err_count);
        if (err_count == 0)
            $display("rtc_alarm_register_block verification clean");
        else
            $display("rtc_alarm_register_block verification failed");
        $finish;
    end

endmodule

@@ rtc_alarm_register_block.f @@
rtl/rtcab_pkg.sv
rtl/rtcab_ns_conv.sv
rtl/rtcab_regfile.sv
rtl/rtc_alarm_register_block.sv
verif/rtc_alarm_register_block_test.sv
